// ===== hdl/link_metric_aggregator_unit_defines.svh =====
// Assertion macros for the link metric aggregator.
`ifndef LINK_METRIC_AGGREGATOR_UNIT_DEFINES_SVH
`define LINK_METRIC_AGGREGATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LMA_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define LMA_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define LMA_ASSERT_IMPL(label, clk, rst_n, a, c)
`define LMA_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== hdl/lma_pkg.sv =====
// ----------------------------------------------------------------------------
// lma_pkg
// Shared constants and types of the link metric aggregator.
// ----------------------------------------------------------------------------
`default_nettype none
package lma_pkg;
	localparam int MAX_LINKS = 256;
	localparam int CNT_W = 17;
	localparam int ACC_W = 48;
	localparam int QUO_W = 31;
	localparam logic [23:0] NO_PATH_COST = 24'd1000000;
	localparam logic [1:0] MODE_BEST = 2'd1;
	localparam logic [1:0] MODE_WORST = 2'd2;
	localparam logic [0:0] REG_MODE = 1'b0;
	localparam logic [0:0] REG_MASK = 1'b1;
	localparam int NUM_METRICS = 7;

	typedef struct packed {
		logic start;
		logic [ACC_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;
endpackage
`default_nettype wire

// ===== hdl/lma_divider.sv =====
// ----------------------------------------------------------------------------
// lma_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "link_metric_aggregator_unit_defines.svh"
module lma_divider (
	input wire logic clk,
	input wire logic arst_n,
	input wire lma_pkg::div_req_t req,
	output logic done,
	output logic [lma_pkg::QUO_W-1:0] quotient
);
	localparam int AW = lma_pkg::ACC_W;
	localparam int CW = lma_pkg::CNT_W;
	localparam int BW = $clog2(AW + 1);
	logic [AW-1:0] num_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] den_q;
	logic [BW-1:0] bit_q;
	logic busy_q;
	logic [CW:0] trial;
	logic [CW:0] diff;

	assign trial = {rem_q, num_q[AW-1]};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			bit_q <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				bit_q <= BW'(AW);
			end else if (busy_q) begin
				bit_q <= bit_q - 1'b1;
				if (bit_q == BW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// The partial remainder stays below the divisor, so CW bits hold it.
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[AW-2:0], !diff[CW]};
			rem_q <= diff[CW] ? trial[CW-1:0] : diff[CW-1:0];
		end
	end
	assign quotient = num_q[lma_pkg::QUO_W-1:0];

	`LMA_ASSERT_NEXT(a_div_done_once, clk, arst_n, done, !done)
	`LMA_ASSERT_IMPL(a_div_start_idle, clk, arst_n, req.start, !busy_q)
	`LMA_ASSERT_IMPL(a_div_nonzero, clk, arst_n, req.start, req.divisor != '0)
endmodule
`default_nettype wire

// ===== hdl/link_metric_aggregator_unit.sv =====
// ----------------------------------------------------------------------------
// link_metric_aggregator_unit
// Folds a batch of link records into one summary word.
// ----------------------------------------------------------------------------
// Each record word is accepted when start is high and busy is low. A record
// that is not the last of its batch is folded in as it is accepted, so busy
// stays low. On the last record of a batch in average mode the seven means
// are formed one after another by a shared bit-serial divider, the sequencer
// passing through the launch and wait states for each; best and worst modes
// and empty batches go from the launch state straight to the emit state. The
// summary is valid for exactly one cycle, marked by done, and cannot be
// stalled, so the receiver must take it in that cycle. busy stays high
// through that cycle and falls once it has passed.
`default_nettype none
`include "link_metric_aggregator_unit_defines.svh"
module link_metric_aggregator_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [0:0] cfg_index,
	input wire logic [4:0] cfg_data,
	input wire logic start,
	output logic busy,
	input wire logic [4:0] record_flags,
	input wire logic [23:0] admin_weight,
	input wire logic [30:0] max_rate,
	input wire logic [30:0] avail_rate,
	input wire logic [23:0] transfer_delay,
	input wire logic [23:0] delay_variation,
	input wire logic [7:0] loss_clp0,
	input wire logic [7:0] loss_clp01,
	input wire logic last_record,
	output logic done,
	output logic [23:0] agg_weight,
	output logic [30:0] agg_max_rate,
	output logic [30:0] agg_avail_rate,
	output logic [23:0] agg_delay,
	output logic [23:0] agg_variation,
	output logic [7:0] agg_loss_clp0,
	output logic [7:0] agg_loss_clp01,
	output logic [8:0] matched,
	output logic overflow
);
	localparam int AW = lma_pkg::ACC_W;
	localparam int CW = lma_pkg::CNT_W;
	localparam int NM = lma_pkg::NUM_METRICS;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LAUNCH = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] mode_q;
	logic [4:0] mask_q;
	logic [AW-1:0] acc_q [NM];
	logic [CW-1:0] count_q;
	logic ovf_q;
	logic [1:0] state_q;
	logic [2:0] idx_q;
	logic [30:0] res_q [NM];
	logic ext_mode;
	logic [AW-1:0] in_val [NM];
	logic take_min [NM];
	lma_pkg::div_req_t dreq;
	logic ddone;
	logic [lma_pkg::QUO_W-1:0] quo;
	logic accept;
	logic pert;

	assign accept = start && !busy;
	assign busy = state_q != ST_IDLE;
	assign ext_mode = (mode_q == lma_pkg::MODE_BEST) || (mode_q == lma_pkg::MODE_WORST);
	assign pert = (record_flags & mask_q) != 5'd0;

	// The summary is presented while the sequencer sits in the emit state; the
	// batch state is cleared only at the edge that ends that cycle.
	assign done = state_q == ST_EMIT;

	assign in_val[0] = AW'(admin_weight);
	assign in_val[1] = AW'(max_rate);
	assign in_val[2] = AW'(avail_rate);
	assign in_val[3] = AW'(transfer_delay);
	assign in_val[4] = AW'(delay_variation);
	assign in_val[5] = AW'(loss_clp0);
	assign in_val[6] = AW'(loss_clp01);

	// Weight, delay and variation prefer small values in best mode; rates
	// and loss values prefer large ones. Worst mode flips each choice.
	always_comb begin
		for (int i = 0; i < NM; i++) begin
			take_min[i] = ((i == 0) || (i == 3) || (i == 4)) ==
				(mode_q == lma_pkg::MODE_BEST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0;
			mask_q <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lma_pkg::REG_MODE: mode_q <= cfg_data[1:0];
				lma_pkg::REG_MASK: mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Batch accumulators and the emit sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NM; i++) acc_q[i] <= '0;
			count_q <= '0;
			ovf_q <= 1'b0;
			state_q <= ST_IDLE;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (pert) begin
							if (count_q >= CW'(lma_pkg::MAX_LINKS)) begin
								ovf_q <= 1'b1;
							end else begin
								count_q <= count_q + 1'b1;
								for (int i = 0; i < NM; i++) begin
									if (ext_mode && count_q != '0) begin
										if (take_min[i] == (in_val[i] < acc_q[i]))
											acc_q[i] <= in_val[i];
									end else begin
										acc_q[i] <= acc_q[i] + in_val[i];
									end
								end
							end
						end
						if (last_record) begin
							idx_q <= '0;
							state_q <= ST_LAUNCH;
						end
					end
				end
				ST_LAUNCH: begin
					if (count_q == '0 || ext_mode) state_q <= ST_EMIT;
					else state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (ddone) begin
						if (idx_q == 3'(NM - 1)) state_q <= ST_EMIT;
						else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_LAUNCH;
						end
					end
				end
				ST_EMIT: begin
					state_q <= ST_IDLE;
					for (int i = 0; i < NM; i++) acc_q[i] <= '0;
					count_q <= '0;
					ovf_q <= 1'b0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT && ddone) res_q[idx_q] <= quo;
	end

	always_comb begin
		dreq.start = (state_q == ST_LAUNCH) && count_q != '0 && !ext_mode;
		dreq.dividend = acc_q[idx_q];
		dreq.divisor = count_q;
	end

	lma_divider u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quotient(quo)
	);

	// Output selection is held stable while done is high.
	always_comb begin
		if (count_q == '0) begin
			agg_weight = lma_pkg::NO_PATH_COST;
			agg_max_rate = '0;
			agg_avail_rate = '0;
			agg_delay = lma_pkg::NO_PATH_COST;
			agg_variation = lma_pkg::NO_PATH_COST;
			agg_loss_clp0 = '0;
			agg_loss_clp01 = '0;
		end else if (ext_mode) begin
			agg_weight = acc_q[0][23:0];
			agg_max_rate = acc_q[1][30:0];
			agg_avail_rate = acc_q[2][30:0];
			agg_delay = acc_q[3][23:0];
			agg_variation = acc_q[4][23:0];
			agg_loss_clp0 = acc_q[5][7:0];
			agg_loss_clp01 = acc_q[6][7:0];
		end else begin
			agg_weight = res_q[0][23:0];
			agg_max_rate = res_q[1];
			agg_avail_rate = res_q[2];
			agg_delay = res_q[3][23:0];
			agg_variation = res_q[4][23:0];
			agg_loss_clp0 = res_q[5][7:0];
			agg_loss_clp01 = res_q[6][7:0];
		end
	end
	assign matched = count_q[8:0];
	assign overflow = ovf_q;

	`LMA_ASSERT_IMPL(a_done_busy, clk, arst_n, done, busy)
	`LMA_ASSERT_NEXT(a_emit_idle, clk, arst_n, state_q == ST_EMIT, state_q == ST_IDLE)
	`LMA_ASSERT_IMPL(a_cnt_cap, clk, arst_n, 1'b1, count_q <= CW'(lma_pkg::MAX_LINKS))
endmodule
`default_nettype wire

// ===== bench/tb_link_metric_aggregator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_link_metric_aggregator_unit
// Self-checking bench for the link metric aggregator. Record words are driven
// through the start/busy handshake and a scoreboard predicts every summary
// word from its own copy of the batch state, then checks it on done.
// ----------------------------------------------------------------------------
`default_nettype none

// Record word as seen by the predictor.
typedef struct {
	logic [4:0] flags;
	logic [23:0] weight;
	logic [30:0] mrate;
	logic [30:0] arate;
	logic [23:0] delay;
	logic [23:0] vari;
	logic [7:0] c0;
	logic [7:0] c01;
	logic last;
} link_rec_t;

// Summary word as delivered on the result ports.
typedef struct {
	logic [23:0] weight;
	logic [30:0] mrate;
	logic [30:0] arate;
	logic [23:0] delay;
	logic [23:0] vari;
	logic [7:0] c0;
	logic [7:0] c01;
	logic [8:0] cnt;
	logic ovf;
} link_sum_t;

class summary_scoreboard;
	logic [1:0] mode;
	logic [4:0] mask;
	logic [63:0] acc[7];
	int unsigned cnt;
	bit ovf;
	link_sum_t pending_sums[$];
	int errors;

	function new();
		mode = 2'd0;
		mask = 5'd1;
		errors = 0;
		clear_batch();
	endfunction

	function void clear_batch();
		foreach (acc[i]) acc[i] = '0;
		cnt = 0;
		ovf = 0;
	endfunction

	// Folds one accepted record into the predicted batch state.
	function void note_record(link_rec_t r);
		logic [63:0] v[7];
		logic [63:0] n;
		bit extreme;
		bit best;
		link_sum_t s;
		v[0] = 64'(r.weight); v[1] = 64'(r.mrate); v[2] = 64'(r.arate);
		v[3] = 64'(r.delay); v[4] = 64'(r.vari); v[5] = 64'(r.c0); v[6] = 64'(r.c01);
		extreme = (mode == lma_pkg::MODE_BEST) || (mode == lma_pkg::MODE_WORST);
		best = (mode == lma_pkg::MODE_BEST);
		if ((r.flags & mask) != 5'd0) begin
			if (cnt >= lma_pkg::MAX_LINKS) begin
				ovf = 1;
			end else if (extreme && cnt != 0) begin
				// In best mode weight, delay and variation favor low values, rates and loss high; worst flips each.
				for (int i = 0; i < 7; i++) begin
					bit want_min;
					want_min = (i == 0 || i == 3 || i == 4) ? best : !best;
					if (want_min) acc[i] = (v[i] < acc[i]) ? v[i] : acc[i];
					else acc[i] = (v[i] > acc[i]) ? v[i] : acc[i];
				end
				cnt++;
			end else begin
				for (int i = 0; i < 7; i++) acc[i] += v[i];
				cnt++;
			end
		end
		if (r.last) begin
			if (cnt == 0) begin
				s.weight = lma_pkg::NO_PATH_COST; s.mrate = '0; s.arate = '0;
				s.delay = lma_pkg::NO_PATH_COST; s.vari = lma_pkg::NO_PATH_COST;
				s.c0 = '0; s.c01 = '0;
			end else if (extreme) begin
				s.weight = acc[0][23:0]; s.mrate = acc[1][30:0]; s.arate = acc[2][30:0];
				s.delay = acc[3][23:0]; s.vari = acc[4][23:0];
				s.c0 = acc[5][7:0]; s.c01 = acc[6][7:0];
			end else begin
				n = 64'(cnt);
				s.weight = 24'(acc[0] / n); s.mrate = 31'(acc[1] / n);
				s.arate = 31'(acc[2] / n);
				s.delay = 24'(acc[3] / n); s.vari = 24'(acc[4] / n);
				s.c0 = 8'(acc[5] / n); s.c01 = 8'(acc[6] / n);
			end
			s.cnt = cnt[8:0];
			s.ovf = ovf;
			pending_sums.push_back(s);
			clear_batch();
		end
	endfunction

	function void report(string f, logic [63:0] e, logic [63:0] a);
		$display("%0t: %s expected %0d actual %0d", $time, f, e, a);
		errors++;
	endfunction

	// Compares one delivered summary with the oldest prediction.
	function void check_summary(link_sum_t a);
		link_sum_t e;
		if (pending_sums.size() == 0) begin
			$display("%0t: unexpected summary word, expected none actual weight %0d",
				$time, a.weight);
			errors++;
			return;
		end
		e = pending_sums.pop_front();
		if (a.weight !== e.weight) report("agg_weight", 64'(e.weight), 64'(a.weight));
		if (a.mrate !== e.mrate) report("agg_max_rate", 64'(e.mrate), 64'(a.mrate));
		if (a.arate !== e.arate) report("agg_avail_rate", 64'(e.arate), 64'(a.arate));
		if (a.delay !== e.delay) report("agg_delay", 64'(e.delay), 64'(a.delay));
		if (a.vari !== e.vari) report("agg_variation", 64'(e.vari), 64'(a.vari));
		if (a.c0 !== e.c0) report("agg_loss_clp0", 64'(e.c0), 64'(a.c0));
		if (a.c01 !== e.c01) report("agg_loss_clp01", 64'(e.c01), 64'(a.c01));
		if (a.cnt !== e.cnt) report("matched", 64'(e.cnt), 64'(a.cnt));
		if (a.ovf !== e.ovf) report("overflow", 64'(e.ovf), 64'(a.ovf));
	endfunction
endclass

module tb_link_metric_aggregator_unit;
	// An idle stretch longer than this, with no word moving, ends the run.
	localparam int WATCHDOG_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [4:0] cfg_data;
	logic start;
	logic busy;
	logic [4:0] record_flags;
	logic [23:0] admin_weight;
	logic [30:0] max_rate;
	logic [30:0] avail_rate;
	logic [23:0] transfer_delay;
	logic [23:0] delay_variation;
	logic [7:0] loss_clp0;
	logic [7:0] loss_clp01;
	logic last_record;
	logic done;
	logic [23:0] agg_weight;
	logic [30:0] agg_max_rate;
	logic [30:0] agg_avail_rate;
	logic [23:0] agg_delay;
	logic [23:0] agg_variation;
	logic [7:0] agg_loss_clp0;
	logic [7:0] agg_loss_clp01;
	logic [8:0] matched;
	logic overflow;

	summary_scoreboard sb;
	int idle_cycles;

	link_metric_aggregator_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .busy(busy),
		.record_flags(record_flags), .admin_weight(admin_weight),
		.max_rate(max_rate), .avail_rate(avail_rate),
		.transfer_delay(transfer_delay), .delay_variation(delay_variation),
		.loss_clp0(loss_clp0), .loss_clp01(loss_clp01), .last_record(last_record),
		.done(done), .agg_weight(agg_weight), .agg_max_rate(agg_max_rate),
		.agg_avail_rate(agg_avail_rate), .agg_delay(agg_delay),
		.agg_variation(agg_variation), .agg_loss_clp0(agg_loss_clp0),
		.agg_loss_clp01(agg_loss_clp01), .matched(matched), .overflow(overflow)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Every input starts at a known value, and reset is held low at the start.
	initial begin
		sb = new();
		arst_n = 0;
		cfg_we = 0; cfg_index = lma_pkg::REG_MODE; cfg_data = 0;
		start = 0; record_flags = 0; admin_weight = 0; max_rate = 0;
		avail_rate = 0; transfer_delay = 0; delay_variation = 0;
		loss_clp0 = 0; loss_clp01 = 0; last_record = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
	end

	// Result side: done marks a summary for one cycle, so it is sampled at
	// every rising edge. The same edge also drives the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				link_sum_t a;
				a.weight = agg_weight; a.mrate = agg_max_rate; a.arate = agg_avail_rate;
				a.delay = agg_delay; a.vari = agg_variation; a.c0 = agg_loss_clp0;
				a.c01 = agg_loss_clp01; a.cnt = matched; a.ovf = overflow;
				sb.check_summary(a);
			end
			if (done || (start && !busy)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end else begin
			idle_cycles <= 0;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("link_metric_aggregator_unit: mismatch");
			$finish;
		end
	end

	// Writes one register; called only while no summary is pending and busy is low. The
	// sender is idle while it runs.
	task automatic write_reg(logic [0:0] idx, logic [4:0] val);
		start <= 0;
		@(posedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == lma_pkg::REG_MODE) sb.mode = val[1:0];
		else sb.mask = val;
	endtask

	// Stops the sender and waits until every predicted summary has come,
	// plus a short settle time.
	task automatic drain_summaries();
		start <= 0;
		while (sb.pending_sums.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Presents one record word, holds it until accepted, then lowers start
	// for the span set by gap unless the next word follows at once. The model is
	// updated at acceptance.
	task automatic send_record(link_rec_t r, int gap);
		start <= 1;
		record_flags <= r.flags; admin_weight <= r.weight; max_rate <= r.mrate;
		avail_rate <= r.arate; transfer_delay <= r.delay; delay_variation <= r.vari;
		loss_clp0 <= r.c0; loss_clp01 <= r.c01; last_record <= r.last;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_record(r);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic link_rec_t rand_record(bit last, bit wide);
		link_rec_t r;
		r.flags = 5'($urandom);
		r.weight = 24'($urandom); r.mrate = 31'($urandom); r.arate = 31'($urandom);
		r.delay = 24'($urandom); r.vari = 24'($urandom);
		r.c0 = 8'($urandom); r.c01 = 8'($urandom);
		// Mostly large values; sometimes small so that comparisons are close.
		if (!wide) begin
			r.weight = 24'($urandom_range(0, 20)); r.mrate = 31'($urandom_range(0, 20));
			r.delay = 24'($urandom_range(0, 20)); r.c0 = 8'($urandom_range(0, 20));
		end
		r.last = last;
		return r;
	endfunction

	function automatic link_rec_t fill_record(logic [4:0] f, bit ones, bit last);
		link_rec_t r;
		r.flags = f;
		r.weight = ones ? '1 : '0; r.mrate = ones ? '1 : '0; r.arate = ones ? '1 : '0;
		r.delay = ones ? '1 : '0; r.vari = ones ? '1 : '0;
		r.c0 = ones ? '1 : '0; r.c01 = ones ? '1 : '0;
		r.last = last;
		return r;
	endfunction

	initial begin
		int sent;
		int len;
		logic [1:0] md;
		@(posedge arst_n);
		@(posedge clk);

		// Directed part: extremes in each mode, an empty batch, mask zero,
		// an unlisted mode value, and a mode change inside a batch.
		for (int m = 0; m < 3; m++) begin
			write_reg(lma_pkg::REG_MODE, 5'(m));
			write_reg(lma_pkg::REG_MASK, 5'd31);
			send_record(fill_record(5'd1, 1, 0), 0);
			send_record(fill_record(5'd16, 0, 0), 0);
			send_record(rand_record(0, 1), 1);
			send_record(fill_record(5'd31, 1, 1), 2);
			drain_summaries();
		end
		write_reg(lma_pkg::REG_MASK, 5'd2);
		send_record(fill_record(5'd1, 1, 1), 0);
		drain_summaries();
		write_reg(lma_pkg::REG_MASK, 5'd0);
		send_record(fill_record(5'd31, 1, 0), 0);
		send_record(fill_record(5'd31, 1, 1), 0);
		drain_summaries();
		write_reg(lma_pkg::REG_MASK, 5'd31);
		write_reg(lma_pkg::REG_MODE, 5'd3);
		send_record(fill_record(5'd4, 1, 0), 0);
		send_record(fill_record(5'd8, 1, 1), 0);
		drain_summaries();
		write_reg(lma_pkg::REG_MODE, 5'(lma_pkg::MODE_BEST));
		send_record(rand_record(0, 1), 0);
		write_reg(lma_pkg::REG_MODE, 5'(lma_pkg::MODE_WORST));
		send_record(rand_record(1, 1), 0);
		drain_summaries();

		// Capacity case: 258 matching records in one batch raise overflow.
		write_reg(lma_pkg::REG_MODE, 5'd0);
		for (int i = 0; i < 258; i++) begin
			link_rec_t r;
			r = rand_record(i == 257, 1);
			r.flags = 5'd31;
			send_record(r, 0);
		end
		drain_summaries();

		// Random part: well-formed batches of random size and content, with
		// settings changed between phases.
		sent = 0;
		while (sent < 680) begin
			md = 2'($urandom_range(0, 3));
			write_reg(lma_pkg::REG_MODE, 5'(md));
			write_reg(lma_pkg::REG_MASK, 5'($urandom_range(0, 31)));
			for (int b = 0; b < 6; b++) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					int gap;
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
					send_record(rand_record(i == len - 1, $urandom_range(0, 3) != 0), gap);
					sent++;
				end
			end
			// The sender holds off here until every summary has come back.
			drain_summaries();
		end

		drain_summaries();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending_sums.size() == 0) begin
			$display("link_metric_aggregator_unit: match");
		end else begin
			$display("link_metric_aggregator_unit: mismatch");
		end
		$finish;
	end
endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/lma_pkg.sv
hdl/lma_divider.sv
hdl/link_metric_aggregator_unit.sv
bench/tb_link_metric_aggregator_unit.sv
